// ----- hdl/rdxc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdxc_pkg: radix converter shared types and constants
// Item structs, register map, reset values and the alphabet lookup.
// ----------------------------------------------------------------------------
package rdxc_pkg;

    localparam int CHAR_W    = 8;
    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int ALPHA_N   = 16;
    localparam int ALPHA_W   = 64;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 6;
    localparam int REG_IDX_W = 3;

    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int DEFAULT_MAX_RADIX   = 16;

    // register indexes, byte address = 8 * index
    localparam logic [REG_IDX_W-1:0] REG_FROM_RADIX = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TO_RADIX   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FROM_LOW   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FROM_HIGH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TO_LOW     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TO_HIGH    = 3'd5;

    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'd3978425819141910832;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'd14648;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
        logic              out_error;
    } out_item_t;

    // pick character k out of a 16-entry packed alphabet
    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [ALPHA_W-1:0] lo,
        input logic [ALPHA_W-1:0] hi,
        input logic [DIGIT_W-1:0] k
    );
        logic [ALPHA_W-1:0] word;
        word = k[3] ? hi : lo;
        return word[{k[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/radix_converter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radix_converter_unit: streaming radix conversion
// Folds source digit characters into a binary value and writes it back out
// in the target alphabet through a shift-subtract divider.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (s_valid/s_ready/s_data): one source character per item,
//   most significant first; in_last marks the final character of a number.
//   Output channel (m_valid/m_ready/m_data): target characters, most
//   significant first, out_last on the final one; an unknown character or an
//   overflow gives one item with out_error and out_last set, out_char zero.
//   APB port: six 64-bit registers at byte address 8*i (radixes, alphabets).
// Sequence
//   Each character is accepted with the alphabet match, then
//   the multiply-add and overflow check run on the accumulator.
//   On the last character a finish step follows, then the bit-serial divider
//   produces each target digit, and each digit is delivered through the digit
//   store read and the output register. The divider loop sets the latency.
//   s_ready is high only in the idle state, between characters' work steps; the next number can be
//   accepted while the final result still waits in the output register.
// Reset and stall
//   Reset restores the register defaults and clears accumulator, error flag
//   and output valid flag. A stalled receiver holds the emit sequence; no item
//   is dropped and none is repeated.
// ----------------------------------------------------------------------------
module radix_converter_unit #(
    parameter int VALUE_WIDTH = rdxc_pkg::DEFAULT_VALUE_WIDTH,
    parameter int MAX_RADIX   = rdxc_pkg::DEFAULT_MAX_RADIX
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // input channel
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire rdxc_pkg::in_item_t         s_data,
    // result channel
    output logic                            m_valid,
    input  wire                             m_ready,
    output rdxc_pkg::out_item_t             m_data,
    // configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [rdxc_pkg::APB_AW-1:0]     paddr,
    input  wire  [rdxc_pkg::APB_DW-1:0]     pwdata,
    output logic [rdxc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import rdxc_pkg::*;

    localparam int IDX_W  = $clog2(VALUE_WIDTH);
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int PROD_W = VALUE_WIDTH + RADIX_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MAC      = 3'd1;
    localparam logic [2:0] ST_FINISH   = 3'd2;
    localparam logic [2:0] ST_DIV      = 3'd3;
    localparam logic [2:0] ST_EMIT_RD  = 3'd4;
    localparam logic [2:0] ST_EMIT_OUT = 3'd5;
    localparam logic [2:0] ST_ERR_OUT  = 3'd6;

    // configuration registers
    logic [RADIX_W-1:0] from_radix_reg;
    logic [RADIX_W-1:0] to_radix_reg;
    logic [ALPHA_W-1:0] from_low_reg;
    logic [ALPHA_W-1:0] from_high_reg;
    logic [ALPHA_W-1:0] to_low_reg;
    logic [ALPHA_W-1:0] to_high_reg;

    // sequencer and datapath state
    logic [2:0]             state_reg,   state_next;
    logic [VALUE_WIDTH-1:0] accum_reg,   accum_next;
    logic                   err_reg,     err_next;
    logic                   found_reg,   found_next;
    logic [DIGIT_W-1:0]     idx_reg,     idx_next;
    logic                   last_reg,    last_next;
    logic [VALUE_WIDTH-1:0] quot_reg,    quot_next;
    logic [DIGIT_W-1:0]     rem_reg,     rem_next;
    logic [IDX_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       ndig_reg,    ndig_next;
    logic [IDX_W-1:0]       rd_ptr_reg,  rd_ptr_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg,  m_data_next;

    // digit store, least significant digit first
    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [DIGIT_W-1:0] mem_wdata;

    logic [RADIX_W-1:0] fr_eff;
    logic [RADIX_W-1:0] tr_eff;
    logic               in_accept;
    logic               out_free;
    logic               cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    logic [ALPHA_N-1:0] hit;
    logic               lk_found;
    logic [DIGIT_W-1:0] lk_idx;

    logic [PROD_W-1:0]  mac_sum;
    logic               mac_ovf;

    logic [DIGIT_W:0]   div_trial;
    logic [DIGIT_W:0]   div_diff;
    logic               div_ge;
    logic [DIGIT_W-1:0] div_rem;
    logic [VALUE_WIDTH-1:0] div_quot;

    // clamp radixes into the supported range
    always_comb begin
        if (from_radix_reg < RADIX_W'(2)) begin
            fr_eff = RADIX_W'(2);
        end else if (from_radix_reg > RADIX_W'(MAX_RADIX)) begin
            fr_eff = RADIX_W'(MAX_RADIX);
        end else begin
            fr_eff = from_radix_reg;
        end
        if (to_radix_reg < RADIX_W'(2)) begin
            tr_eff = RADIX_W'(2);
        end else if (to_radix_reg > RADIX_W'(MAX_RADIX)) begin
            tr_eff = RADIX_W'(MAX_RADIX);
        end else begin
            tr_eff = to_radix_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // alphabet match: lowest matching index wins
    always_comb begin
        lk_found = 1'b0;
        lk_idx   = '0;
        for (int k = 0; k < ALPHA_N; k++) begin
            hit[k] = (RADIX_W'(k) < fr_eff) &&
                     (alpha_char(from_low_reg, from_high_reg, DIGIT_W'(k)) == s_data.in_char);
        end
        for (int k = ALPHA_N - 1; k >= 0; k--) begin
            if (hit[k]) begin
                lk_found = 1'b1;
                lk_idx   = DIGIT_W'(k);
            end
        end
    end

    // multiply-add with overflow detect
    assign mac_sum = PROD_W'(accum_reg) * PROD_W'(fr_eff) + PROD_W'(idx_reg);
    assign mac_ovf = |mac_sum[PROD_W-1:VALUE_WIDTH];

    // one restoring division step
    assign div_trial = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign div_diff  = div_trial - tr_eff;
    assign div_ge    = (div_trial >= tr_eff);
    assign div_rem   = div_ge ? div_diff[DIGIT_W-1:0] : div_trial[DIGIT_W-1:0];
    assign div_quot  = {quot_reg[VALUE_WIDTH-2:0], div_ge};

    always_comb begin
        state_next   = state_reg;
        accum_next   = accum_reg;
        err_next     = err_reg;
        found_next   = found_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        ndig_next    = ndig_reg;
        rd_ptr_next  = rd_ptr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_wdata    = div_rem;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    found_next = lk_found;
                    idx_next   = lk_idx;
                    last_next  = s_data.in_last;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                // after an error, take characters in but leave the value alone
                if (!err_reg) begin
                    if (!found_reg || mac_ovf) begin
                        err_next = 1'b1;
                    end else begin
                        accum_next = mac_sum[VALUE_WIDTH-1:0];
                    end
                end
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                quot_next    = accum_reg;
                rem_next     = '0;
                bit_cnt_next = '0;
                ndig_next    = '0;
                accum_next   = '0;
                err_next     = 1'b0;
                state_next   = err_reg ? ST_ERR_OUT : ST_DIV;
            end
            ST_DIV: begin
                quot_next    = div_quot;
                rem_next     = div_rem;
                bit_cnt_next = bit_cnt_reg + IDX_W'(1);
                if (bit_cnt_reg == IDX_W'(VALUE_WIDTH - 1)) begin
                    // digit done: store remainder, restart on the quotient
                    mem_we       = 1'b1;
                    ndig_next    = ndig_reg + CNT_W'(1);
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    if (div_quot == '0) begin
                        rd_ptr_next = ndig_reg[IDX_W-1:0];
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_char  = alpha_char(to_low_reg, to_high_reg, rd_data_reg);
                    m_data_next.out_last  = (rd_ptr_reg == '0);
                    m_data_next.out_error = 1'b0;
                    if (rd_ptr_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_ptr_next = rd_ptr_reg - IDX_W'(1);
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            ST_ERR_OUT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_char  = '0;
                    m_data_next.out_last  = 1'b1;
                    m_data_next.out_error = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            accum_reg   <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            accum_reg   <= accum_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg   <= found_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        ndig_reg    <= ndig_next;
        rd_ptr_reg  <= rd_ptr_next;
        m_data_reg  <= m_data_next;
    end

    // digit store: write during division, registered read during emit
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[ndig_reg[IDX_W-1:0]] <= mem_wdata;
        end
        if (state_reg == ST_EMIT_RD) begin
            rd_data_reg <= digit_mem[rd_ptr_reg];
        end
    end

    // APB register file
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_AW-1:3];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            from_radix_reg <= RADIX_RESET;
            to_radix_reg   <= RADIX_RESET;
            from_low_reg   <= ALPHA_LOW_RESET;
            from_high_reg  <= ALPHA_HIGH_RESET;
            to_low_reg     <= ALPHA_LOW_RESET;
            to_high_reg    <= ALPHA_HIGH_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_FROM_RADIX: from_radix_reg <= pwdata[RADIX_W-1:0];
                REG_TO_RADIX:   to_radix_reg   <= pwdata[RADIX_W-1:0];
                REG_FROM_LOW:   from_low_reg   <= pwdata;
                REG_FROM_HIGH:  from_high_reg  <= pwdata;
                REG_TO_LOW:     to_low_reg     <= pwdata;
                REG_TO_HIGH:    to_high_reg    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FROM_RADIX: prdata = APB_DW'(from_radix_reg);
            REG_TO_RADIX:   prdata = APB_DW'(to_radix_reg);
            REG_FROM_LOW:   prdata = from_low_reg;
            REG_FROM_HIGH:  prdata = from_high_reg;
            REG_TO_LOW:     prdata = to_low_reg;
            REG_TO_HIGH:    prdata = to_high_reg;
            default:        prdata = '0;
        endcase
    end

`ifndef SYNTH
    // an error result is always a lone final item with a zero character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_error |-> m_data.out_last && (m_data.out_char == '0))
        else $error("error result not final or carries a character");

    // an accepted item drops s_ready, so the next one must wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // divider remainder stays below the target radix
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (RADIX_W'(rem_reg) < tr_eff))
        else $error("divider remainder out of range");
`endif

endmodule
`default_nettype wire

// ----- tb/rdxc_conversion_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdxc_conversion_checker: radix conversion predictor and result comparator
// Tracks the register writes, folds every accepted source character into its
// own accumulator and queues the target characters that each number must
// produce; every result item is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module rdxc_conversion_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  rdxc_pkg::in_item_t            s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  rdxc_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [rdxc_pkg::APB_AW-1:0]   paddr,
    input  logic [rdxc_pkg::APB_DW-1:0]   pwdata,
    output int                            fail_count,
    output int                            outstanding,
    output int                            checked_count
);
    import rdxc_pkg::*;

    localparam int          VALUE_BITS = 64;
    localparam logic [63:0] VALUE_MAX  = {64{1'b1}} >> (64 - VALUE_BITS);

    logic [RADIX_W-1:0] src_radix, dst_radix;
    logic [ALPHA_W-1:0] src_lo, src_hi, dst_lo, dst_hi;
    logic [63:0]        acc;
    logic               bad_number;
    out_item_t          pending_chars[$];
    out_item_t          want;
    int                 fails = 0;
    int                 checked = 0;

    function automatic logic [7:0] alphabet_at(input logic [63:0] lo, input logic [63:0] hi,
                                               input int k);
        logic [63:0] word;
        word = (k < 8) ? lo : hi;
        return word[8*(k%8) +: 8];
    endfunction

    function automatic int effective_radix(input logic [RADIX_W-1:0] r);
        if (r < 2) return 2;
        if (r > 16) return 16;
        return int'(r);
    endfunction

    // fold one source character; on the last one queue the target characters
    function automatic void convert_char(input in_item_t it);
        int          fr, tr, idx, n;
        bit          hit;
        logic [63:0] v;
        logic [3:0]  digits [64];
        out_item_t   res;
        fr = effective_radix(src_radix);
        if (!bad_number) begin
            hit = 1'b0;
            idx = 0;
            for (int k = 0; k < fr; k++) begin
                if (!hit && alphabet_at(src_lo, src_hi, k) == it.in_char) begin
                    hit = 1'b1;
                    idx = k;
                end
            end
            if (!hit)
                bad_number = 1'b1;
            else if (acc > (VALUE_MAX - 64'(idx)) / 64'(fr))
                bad_number = 1'b1;
            else
                acc = acc * 64'(fr) + 64'(idx);
        end
        if (it.in_last) begin
            if (bad_number) begin
                res.out_char  = '0;
                res.out_last  = 1'b1;
                res.out_error = 1'b1;
                pending_chars.push_back(res);
            end else begin
                tr = effective_radix(dst_radix);
                v  = acc;
                n  = 0;
                do begin
                    digits[n] = 4'(v % 64'(tr));
                    v = v / 64'(tr);
                    n++;
                end while (v != 0 && n < 64);
                for (int i = n - 1; i >= 0; i--) begin
                    res.out_char  = alphabet_at(dst_lo, dst_hi, int'(digits[i]));
                    res.out_last  = (i == 0);
                    res.out_error = 1'b0;
                    pending_chars.push_back(res);
                end
            end
            acc        = '0;
            bad_number = 1'b0;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            src_radix  = RADIX_RESET;
            dst_radix  = RADIX_RESET;
            src_lo     = ALPHA_LOW_RESET;
            src_hi     = ALPHA_HIGH_RESET;
            dst_lo     = ALPHA_LOW_RESET;
            dst_hi     = ALPHA_HIGH_RESET;
            acc        = '0;
            bad_number = 1'b0;
            pending_chars.delete();
        end else begin
            // compare before predicting, so a stray result never meets a fresh entry
            if (m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    $error("result item with nothing expected: out_char %02h out_last %0b out_error %0b",
                           m_data.out_char, m_data.out_last, m_data.out_error);
                    fails++;
                end else begin
                    want = pending_chars.pop_front();
                    checked++;
                    if (m_data.out_char !== want.out_char) begin
                        $error("out_char: expected %02h, actual %02h",
                               want.out_char, m_data.out_char);
                        fails++;
                    end
                    if (m_data.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, actual %0b",
                               want.out_last, m_data.out_last);
                        fails++;
                    end
                    if (m_data.out_error !== want.out_error) begin
                        $error("out_error: expected %0b, actual %0b",
                               want.out_error, m_data.out_error);
                        fails++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:3])
                    REG_FROM_RADIX: src_radix = pwdata[RADIX_W-1:0];
                    REG_TO_RADIX:   dst_radix = pwdata[RADIX_W-1:0];
                    REG_FROM_LOW:   src_lo    = pwdata;
                    REG_FROM_HIGH:  src_hi    = pwdata;
                    REG_TO_LOW:     dst_lo    = pwdata;
                    REG_TO_HIGH:    dst_hi    = pwdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                convert_char(s_data);
        end
        outstanding   <= pending_chars.size();
        fail_count    <= fails;
        checked_count <= checked;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: radix converter testbench
// Streams source numbers one character per item through the converter under
// a series of radix and alphabet settings, with random gaps on both channels;
// the conversion checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
    import rdxc_pkg::*;

    // Slowest correct run: at most 119 numbers, each at worst giving 64 binary digits
    // through the divider plus delivery and receiver stalls; the limit allows
    // several times that.
    localparam int LIMIT_CYCLES  = 4_000_000;
    // one full 64-digit emit sequence plus margin
    localparam int TAIL_CYCLES   = 300;
    // cover the accumulate steps of a character that has no result
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_ITEMS   = 14;
    localparam int N_PHASES      = 8;

    localparam logic [63:0] DEC_LO       = ALPHA_LOW_RESET;
    localparam logic [63:0] DEC_HI       = ALPHA_HIGH_RESET;
    localparam logic [63:0] HEX_LO       = 64'h3736353433323130;  // "01234567"
    localparam logic [63:0] HEX_HI_UPPER = 64'h4645444342413938;  // "89ABCDEF"
    localparam logic [63:0] HEX_HI_LOWER = 64'h6665646362613938;  // "89abcdef"

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int outstanding;
    int checked_count;
    int cycles       = 0;
    bit steady       = 1'b0;   // high: neither side idles
    int numbers_sent = 0;
    int chars_sent   = 0;

    // stimulus copy of the source side, used only to build well-formed digits
    logic [RADIX_W-1:0] cur_src_radix = RADIX_RESET;
    logic [63:0]        cur_src_lo    = ALPHA_LOW_RESET;
    logic [63:0]        cur_src_hi    = ALPHA_HIGH_RESET;

    radix_converter_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rdxc_conversion_checker conv_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: give up on a hung block.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: stall at random with a chance of about 16 in 100, never during the steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 16);
    end

    function automatic int src_radix_eff();
        if (cur_src_radix < 2) return 2;
        if (cur_src_radix > 16) return 16;
        return int'(cur_src_radix);
    endfunction

    function automatic logic [7:0] src_glyph(input int k);
        return (k < 8) ? cur_src_lo[8*k +: 8] : cur_src_hi[8*(k-8) +: 8];
    endfunction

    // Offer one character; idle at random first, then hold valid until taken.
    // Valid is only dropped inside the idle loop or in wait_drained, so it never toggles within a step.
    task automatic push_char(input logic [7:0] c, input logic last);
        in_item_t it;
        while (!steady && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        it.in_char = c;
        it.in_last = last;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
    endtask

    task automatic send_digits(input string txt);
        for (int i = 0; i < txt.len(); i++)
            push_char(txt[i], i == txt.len() - 1);
        numbers_sent++;
    endtask

    // Hold the sender until every predicted result item has been delivered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Write all six registers back to back; psel stays high between writes.
    task automatic load_config(input logic [RADIX_W-1:0] fr, input logic [RADIX_W-1:0] tr,
                               input logic [63:0] flo, input logic [63:0] fhi,
                               input logic [63:0] tlo, input logic [63:0] thi);
        logic [REG_IDX_W-1:0] idx [6];
        logic [63:0]          val [6];
        idx = '{REG_FROM_RADIX, REG_TO_RADIX, REG_FROM_LOW, REG_FROM_HIGH,
                REG_TO_LOW, REG_TO_HIGH};
        val = '{64'(fr), 64'(tr), flo, fhi, tlo, thi};
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (int i = 0; i < 6; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx[i], 3'b000};
            pwdata  <= val[i];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_src_radix = fr;
        cur_src_lo    = flo;
        cur_src_hi    = fhi;
    endtask

    // One random number. Mostly well-formed digit runs; long runs near the
    // 64-bit ceiling to provoke overflow; a stray byte at a random place; pure noise.
    task automatic send_number();
        int          mode, len, fr, pos, nmax;
        logic [63:0] v;
        logic [7:0]  c;
        fr   = src_radix_eff();
        mode = $urandom_range(0, 99);
        // keep long runs short in items: only for the wider source radixes
        if (mode >= 65 && mode < 78 && fr < 8)
            mode = 0;
        if (mode < 65) begin
            len = $urandom_range(1, 6);
            for (int p = 0; p < len; p++)
                push_char(src_glyph($urandom_range(0, fr - 1)), p == len - 1);
        end else if (mode < 78) begin
            // digits of the largest value in this radix, give or take one
            v    = '1;
            nmax = 0;
            while (v != 0) begin
                v = v / 64'(fr);
                nmax++;
            end
            len = nmax - 1 + $urandom_range(0, 2);
            for (int p = 0; p < len; p++)
                push_char(src_glyph($urandom_range(0, fr - 1)), p == len - 1);
        end else if (mode < 90) begin
            len = $urandom_range(1, 5);
            pos = $urandom_range(0, len - 1);
            for (int p = 0; p < len; p++) begin
                c = (p == pos) ? 8'($urandom_range(0, 255))
                               : src_glyph($urandom_range(0, fr - 1));
                push_char(c, p == len - 1);
            end
        end else begin
            len = $urandom_range(1, 4);
            for (int p = 0; p < len; p++)
                push_char(8'($urandom_range(0, 255)), p == len - 1);
        end
        numbers_sent++;
    endtask

    initial begin
        int          phase_base;
        logic [63:0] ra, rb;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset settings (decimal to decimal): zero gives one digit,
        // a plain digit, an unknown character followed by a valid one, the
        // all-ones and all-zeros bytes, and an ordinary multi-digit number.
        send_digits("0");
        send_digits("9");
        send_digits("x5");
        push_char(8'hFF, 1'b1);
        numbers_sent++;
        push_char(8'h00, 1'b1);
        numbers_sent++;
        send_digits("123");

        // Hex to binary: the largest 64-bit value, 64 output digits.
        wait_drained();
        load_config(5'd16, 5'd2, HEX_LO, HEX_HI_UPPER, DEC_LO, DEC_HI);
        send_digits("FFFFFFFFFFFFFFFF");

        for (int ph = 1; ph <= N_PHASES; ph++) begin
            if (ph > 1) begin
                wait_drained();
                ra = {$urandom, $urandom};
                rb = {$urandom, $urandom};
                case (ph)
                    2: load_config(5'd2, 5'd16, DEC_LO, DEC_HI, HEX_LO, HEX_HI_LOWER);
                    // radixes past both ends clamp to 2 and 16
                    3: load_config(5'd0, 5'd31, ra, rb, {$urandom, $urandom},
                                   {$urandom, $urandom});
                    // repeated alphabet: upper half copies the lower, lowest index wins
                    4: load_config(5'd17, 5'd1, ra, ra, HEX_LO, HEX_HI_UPPER);
                    5: load_config(RADIX_RESET, RADIX_RESET, DEC_LO, DEC_HI, DEC_LO, DEC_HI);
                    8: load_config(5'd31, 5'd0, HEX_LO, HEX_HI_LOWER, ra, rb);
                    default: load_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                         ra, rb, {$urandom, $urandom}, {$urandom, $urandom});
                endcase
            end
            // one whole phase with no idling on either side
            steady <= (ph == 3);
            phase_base = chars_sent;
            while (chars_sent - phase_base < PHASE_ITEMS)
                send_number();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Converted %0d numbers (%0d characters, %0d results) under %0d settings,",
                 numbers_sent, chars_sent, checked_count, N_PHASES + 1);
        $display("covering clamped radixes, repeated alphabets, bad characters and overflow.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
